// ===== src/bprs_pkg.sv =====
package bprs_pkg;

	localparam int ROWS_DEF  = 8;
	localparam int ROW_BITS  = 8;
	localparam int PRIO_W    = 6;
	localparam int DEPTH_W   = 8;
	localparam int TOTAL_W   = 32;
	localparam logic [DEPTH_W-1:0] DEPTH_MAX = 8'd255;

	typedef enum logic [2:0] {
		KIND_READY     = 3'd0,
		KIND_UNREADY   = 3'd1,
		KIND_INT_ENTER = 3'd2,
		KIND_INT_EXIT  = 3'd3,
		KIND_LOCK      = 3'd4,
		KIND_UNLOCK    = 3'd5,
		KIND_SCHEDULE  = 3'd6,
		KIND_START     = 3'd7
	} kind_t;

	typedef struct packed {
		logic [2:0]        kind;
		logic [PRIO_W-1:0] prio;
	} cmd_t;

	typedef struct packed {
		logic [PRIO_W-1:0]  highest_ready;
		logic               switch_now;
		logic [PRIO_W-1:0]  current_prio;
		logic [TOTAL_W-1:0] switch_total;
		logic               is_running;
	} result_t;

	typedef struct packed {
		logic               switch_now;
		logic [PRIO_W-1:0]  current_prio;
		logic [TOTAL_W-1:0] switch_total;
		logic               is_running;
	} sched_stat_t;

	function automatic logic [2:0] lowest_bit(input logic [ROW_BITS-1:0] m);
		logic [2:0] idx;
		idx = 3'd0;
		for (int i = ROW_BITS - 1; i >= 0; i--) begin
			if (m[i]) begin
				idx = 3'(i);
			end
		end
		return idx;
	endfunction

endpackage

// ===== src/bprs_ready_set.sv =====
module bprs_ready_set #(
	parameter int ROWS = bprs_pkg::ROWS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      upd,
	input  logic                      set,
	input  logic [bprs_pkg::PRIO_W-1:0] prio,
	output logic [bprs_pkg::PRIO_W-1:0] highest
);
	import bprs_pkg::*;

	logic [ROW_BITS-1:0] rows_q [ROWS];
	logic [ROW_BITS-1:0] rows_n [ROWS];
	logic [2:0]          row_y;
	logic [2:0]          bit_x;
	logic [ROW_BITS-1:0] bit_oh;
	logic [ROW_BITS-1:0] grp;
	logic [ROW_BITS-1:0] row_sel;
	logic [2:0]          y_h;

	assign row_y  = prio[PRIO_W-1:3];
	assign bit_x  = prio[2:0];
	assign bit_oh = ROW_BITS'(1) << bit_x;

	always_comb begin
		for (int i = 0; i < ROWS; i++) begin
			rows_n[i] = rows_q[i];
			if (upd && row_y == 3'(i)) begin
				rows_n[i] = set ? (rows_q[i] | bit_oh) : (rows_q[i] & ~bit_oh);
			end
		end
	end

	// group bit is set exactly when its row is not empty
	always_comb begin
		grp     = '0;
		row_sel = '0;
		for (int i = 0; i < ROWS; i++) begin
			grp[i] = |rows_n[i];
		end
		y_h = lowest_bit(grp);
		for (int i = 0; i < ROWS; i++) begin
			if (y_h == 3'(i)) begin
				row_sel = rows_n[i];
			end
		end
		highest = {y_h, lowest_bit(row_sel)};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ROWS; i++) begin
				rows_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < ROWS; i++) begin
				rows_q[i] <= rows_n[i];
			end
		end
	end

endmodule

// ===== src/bprs_sched.sv =====
module bprs_sched (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        vld,
	input  logic [2:0]                  kind,
	input  logic [bprs_pkg::PRIO_W-1:0] highest,
	output bprs_pkg::sched_stat_t       stat
);
	import bprs_pkg::*;

	logic [DEPTH_W-1:0] int_q, int_n;
	logic [DEPTH_W-1:0] lock_q, lock_n;
	logic [PRIO_W-1:0]  cur_q, cur_n;
	logic [TOTAL_W-1:0] cnt_q, cnt_n;
	logic               run_q, run_n;
	logic               pt;
	logic               sw;

	always_comb begin
		int_n  = int_q;
		lock_n = lock_q;
		cur_n  = cur_q;
		cnt_n  = cnt_q;
		run_n  = run_q;
		pt     = 1'b0;
		sw     = 1'b0;
		case (kind_t'(kind))
			KIND_INT_ENTER: begin
				if (run_q && int_q != DEPTH_MAX) int_n = int_q + 1'b1;
			end
			KIND_INT_EXIT: begin
				if (run_q) begin
					if (int_q != '0) int_n = int_q - 1'b1;
					pt = 1'b1;
				end
			end
			KIND_LOCK: begin
				if (run_q && lock_q != DEPTH_MAX) lock_n = lock_q + 1'b1;
			end
			KIND_UNLOCK: begin
				if (run_q && lock_q != '0) begin
					lock_n = lock_q - 1'b1;
					pt     = 1'b1;
				end
			end
			KIND_SCHEDULE: begin
				pt = 1'b1;
			end
			KIND_START: begin
				if (!run_q) begin
					cur_n = highest;
					run_n = 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (pt && int_n == '0 && lock_n == '0 && highest != cur_q) begin
			sw    = 1'b1;
			cur_n = highest;
			cnt_n = cnt_q + 1'b1;
		end
	end

	assign stat.switch_now   = sw;
	assign stat.current_prio = cur_n;
	assign stat.switch_total = cnt_n;
	assign stat.is_running   = run_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			int_q  <= '0;
			lock_q <= '0;
			cur_q  <= '0;
			cnt_q  <= '0;
			run_q  <= 1'b0;
		end else if (vld) begin
			int_q  <= int_n;
			lock_q <= lock_n;
			cur_q  <= cur_n;
			cnt_q  <= cnt_n;
			run_q  <= run_n;
		end
	end

endmodule

// ===== src/bitmap_priority_ready_scheduler.sv =====
// pipeline: a word taken at a clock edge is held in the input register, and its result
// is then held in the result register, from which it is shown with done high
// throughput: one word every cycle, busy never rises; the receiver cannot stall
// reset: arst_n low clears the ready rows, nesting depths, current priority,
// switch count and the running flag at once; no clearing pass is needed
module bitmap_priority_ready_scheduler #(
	parameter int ROWS = bprs_pkg::ROWS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  bprs_pkg::cmd_t    cmd,
	output logic              done,
	output bprs_pkg::result_t result
);
	import bprs_pkg::*;

	logic        vld_s1;
	cmd_t        cmd_s1;
	logic        upd;
	logic [PRIO_W-1:0] highest;
	sched_stat_t stat;
	logic        done_s2;
	result_t     result_s2;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_s1 <= cmd;
		end
	end

	assign upd = vld_s1 &&
		(kind_t'(cmd_s1.kind) == KIND_READY || kind_t'(cmd_s1.kind) == KIND_UNREADY);

	bprs_ready_set #(
		.ROWS(ROWS)
	) u_ready_set (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (upd),
		.set    (kind_t'(cmd_s1.kind) == KIND_READY),
		.prio   (cmd_s1.prio),
		.highest(highest)
	);

	bprs_sched u_sched (
		.clk    (clk),
		.arst_n (arst_n),
		.vld    (vld_s1),
		.kind   (cmd_s1.kind),
		.highest(highest),
		.stat   (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			result_s2.highest_ready <= highest;
			result_s2.switch_now    <= stat.switch_now;
			result_s2.current_prio  <= stat.current_prio;
			result_s2.switch_total  <= stat.switch_total;
			result_s2.is_running    <= stat.is_running;
		end
	end

	assign done   = done_s2;
	assign result = result_s2;

endmodule

// ===== src/bprs_checker.sv =====
module bprs_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input bprs_pkg::cmd_t    cmd,
	input logic              done,
	input bprs_pkg::result_t result
);
	import bprs_pkg::*;

	// every accepted word gives a result
	a_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("accepted word gave no result");

	a_bwd: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(arst_n, 2)) |-> $past(start && !busy, 2))
		else $error("result without an accepted word");

	// a switch moves the current priority to the highest ready one
	a_sw: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.switch_now) |-> (result.current_prio == result.highest_ready))
		else $error("switch to a priority other than the highest ready");

	a_run: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(done) && $past(result.is_running)) |-> result.is_running)
		else $error("running flag dropped");

endmodule

bind bitmap_priority_ready_scheduler bprs_checker u_bprs_checker (.*);
